@@ hw/rtl/guest_range_map_table_assert.svh @@
// Assertion macros used by the top level of the range map table RTL.
`ifndef GUEST_RANGE_MAP_TABLE_ASSERT_SVH
`define GUEST_RANGE_MAP_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GRM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/grm_pkg.sv @@
// Shared widths, codes and types of the guest range map table.
`default_nettype none

package grm_pkg;

    localparam int ADDR_W = 48;           // guest address and object offset
    localparam int SIZE_W = ADDR_W + 1;   // lengths and sizes up to 2^ADDR_W
    localparam int SUM_W  = ADDR_W + 2;   // base + length without wrap
    localparam int OBJ_W  = 8;
    localparam int PROT_W = 3;
    localparam int STAT_W = 3;
    localparam int GEN_W  = 64;
    localparam int OP_W   = 2;

    localparam int PAGE_BYTES = 4096;
    localparam logic [SIZE_W-1:0] SPACE_RESET = SIZE_W'(1) << ADDR_W;

    // request opcodes
    localparam logic [OP_W-1:0] OP_MAP    = 2'd0;
    localparam logic [OP_W-1:0] OP_UNMAP  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    // response status codes
    localparam logic [STAT_W-1:0] RS_OK        = 3'd0;
    localparam logic [STAT_W-1:0] RS_INVALID   = 3'd1;
    localparam logic [STAT_W-1:0] RS_NO_SPACE  = 3'd2;
    localparam logic [STAT_W-1:0] RS_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] RS_DENIED    = 3'd4;
    localparam logic [STAT_W-1:0] RS_FULL      = 3'd5;

    // one stored range
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] length;
        logic [ADDR_W-1:0] offset;
        logic [PROT_W-1:0] prot;
        logic [OBJ_W-1:0]  object;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_SCAN,
        S_TAIL,
        S_FIX,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;     // capture the request fields
        logic prep;     // derive range bounds, clear scan trackers
        logic rd_en;    // read one table entry
        logic fix;      // compute offset delta of the matched entry
        logic commit;   // update table, load response register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free; // response register can take a new result
    } t_dp_stat;

endpackage

`default_nettype wire

@@ hw/rtl/grm_ifs.sv @@
// Request and response channel interfaces of the range map table.
`default_nettype none

interface grm_req_if import grm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] length;
    logic [OBJ_W-1:0]  object_id;
    logic [ADDR_W-1:0] object_offset;
    logic [SIZE_W-1:0] object_size;
    logic [PROT_W-1:0] prot;

    modport source (
        output valid, op, addr, length, object_id, object_offset, object_size, prot,
        input  ready
    );
    modport sink (
        input  valid, op, addr, length, object_id, object_offset, object_size, prot,
        output ready
    );
endinterface

interface grm_rsp_if import grm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [OBJ_W-1:0]  found_object;
    logic [ADDR_W-1:0] found_offset;
    logic [GEN_W-1:0]  generation;

    modport source (
        output valid, status, found_object, found_offset, generation,
        input  ready
    );
    modport sink (
        input  valid, status, found_object, found_offset, generation,
        output ready
    );
endinterface

`default_nettype wire

@@ hw/rtl/grm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module grm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                     i_wr_data,
    input  wire logic                                 i_rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/grm_ctrl.sv @@
// Sequencer of the range map table: request intake, table scan, commit.
`default_nettype none

module grm_ctrl import grm_pkg::*; #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_req_valid,
    output logic                      o_req_ready,
    input  wire t_dp_stat             i_stat,
    output t_dp_cmd                   o_cmd,
    output logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] o_rd_addr
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;

    // state and scan index registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) n_state = S_PREP;
            end
            S_PREP: n_state = S_SCAN;
            S_SCAN: begin
                if (r_idx == LAST_IDX) n_state = S_TAIL;
            end
            S_TAIL: n_state = S_FIX;
            S_FIX:  n_state = S_DONE;
            S_DONE: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // scan index: one entry per cycle
    always_comb begin
        n_idx = r_idx;
        if (r_state == S_PREP) begin
            n_idx = '0;
        end else if (r_state == S_SCAN && r_idx != LAST_IDX) begin
            n_idx = r_idx + IDX_W'(1);
        end
    end

    // outputs
    always_comb begin
        o_req_ready = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                o_cmd.load  = i_req_valid;
            end
            S_PREP: o_cmd.prep  = 1'b1;
            S_SCAN: o_cmd.rd_en = 1'b1;
            S_TAIL: ;
            S_FIX:  o_cmd.fix   = 1'b1;
            S_DONE: o_cmd.commit = i_stat.out_free;
            default: ;
        endcase
    end

    assign o_rd_addr = r_idx;

endmodule

`default_nettype wire

@@ hw/rtl/grm_dp.sv @@
// Datapath of the range map table: checks, entry compare, table and response.
`default_nettype none

module grm_dp import grm_pkg::*; #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [SIZE_W-1:0] i_cfg_wr_data,
    input  wire t_dp_cmd           i_cmd,
    input  wire logic [(MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1)-1:0] i_rd_addr,
    output t_dp_stat               o_stat,
    input  wire logic [OP_W-1:0]   i_op,
    input  wire logic [ADDR_W-1:0] i_addr,
    input  wire logic [SIZE_W-1:0] i_length,
    input  wire logic [OBJ_W-1:0]  i_object_id,
    input  wire logic [ADDR_W-1:0] i_object_offset,
    input  wire logic [SIZE_W-1:0] i_object_size,
    input  wire logic [PROT_W-1:0] i_prot,
    output logic                   o_rsp_valid,
    input  wire logic              i_rsp_ready,
    output logic [STAT_W-1:0]      o_status,
    output logic [OBJ_W-1:0]       o_found_object,
    output logic [ADDR_W-1:0]      o_found_offset,
    output logic [GEN_W-1:0]       o_generation
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    // configuration
    logic [SIZE_W-1:0] r_space_size;

    // captured request
    logic [OP_W-1:0]   r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [SIZE_W-1:0] r_len;
    logic [OBJ_W-1:0]  r_obj;
    logic [ADDR_W-1:0] r_off;
    logic [SIZE_W-1:0] r_osize;
    logic [PROT_W-1:0] r_prot;

    // derived bounds
    logic              r_arg_bad;
    logic              r_addr_oor;
    logic [SUM_W-1:0]  r_last;
    logic [SUM_W-1:0]  r_page_end;

    // table valid bits and read pipeline
    logic [MAX_ENTRIES-1:0] r_valid;
    logic                   r_valid_q;
    logic                   r_cmp_vld;
    logic [IDX_W-1:0]       r_cmp_idx;
    t_entry                 w_rd_data;

    // scan trackers
    logic              r_hit, r_ovl, r_free;
    logic [IDX_W-1:0]  r_free_idx, r_match_idx;
    t_entry            r_m;
    logic              r_m_short, r_m_exact;
    logic [ADDR_W-1:0] r_delta;

    // generation and response
    logic [GEN_W-1:0]  r_gen;
    logic              r_rsp_valid;
    logic [STAT_W-1:0] r_status;
    logic [OBJ_W-1:0]  r_fobj;
    logic [ADDR_W-1:0] r_foff;
    logic [GEN_W-1:0]  r_out_gen;

    logic [STAT_W-1:0] n_status;
    logic [OBJ_W-1:0]  n_fobj;
    logic [ADDR_W-1:0] n_foff;
    logic [GEN_W-1:0]  n_gen;
    logic              w_map_ok, w_unmap_ok;

    logic [SUM_W-1:0]  w_end;
    logic              w_live, w_contains, w_overlap;
    t_entry            w_wr_data;

    // space size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_space_size <= SPACE_RESET;
        end else if (i_cfg_wr_en) begin
            r_space_size <= i_cfg_wr_data;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_addr  <= i_addr;
            r_len   <= i_length;
            r_obj   <= i_object_id;
            r_off   <= i_object_offset;
            r_osize <= i_object_size;
            r_prot  <= i_prot;
        end
    end

    // argument checks and range bounds
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_arg_bad  <= (r_len == '0) ||
                          ((SUM_W'(r_off) + SUM_W'(r_len)) > SUM_W'(r_osize));
            r_addr_oor <= SIZE_W'(r_addr) >= r_space_size;
            r_last     <= SUM_W'(r_addr) + SUM_W'(r_len) - SUM_W'(1);
            r_page_end <= SUM_W'(r_addr) + SUM_W'(PAGE_BYTES);
        end
    end

    // entry storage
    grm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.commit && w_map_ok),
        .i_wr_addr (r_free_idx),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        w_wr_data.base   = r_addr;
        w_wr_data.length = r_len;
        w_wr_data.offset = r_off;
        w_wr_data.prot   = r_prot;
        w_wr_data.object = r_obj;
    end

    // read data lines up with its index and valid bit, each registered alongside the RAM read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_cmp_idx <= i_rd_addr;
            r_valid_q <= r_valid[i_rd_addr];
        end
    end

    // per-entry compare
    always_comb begin
        w_end      = SUM_W'(w_rd_data.base) + SUM_W'(w_rd_data.length);
        w_live     = r_cmp_vld && r_valid_q;
        w_contains = w_live && (r_addr >= w_rd_data.base) && (SUM_W'(r_addr) < w_end);
        w_overlap  = w_live && (SUM_W'(w_rd_data.base) <= r_last) &&
                     (SUM_W'(r_addr) < w_end);
    end

    // scan trackers: first free slot, first containing entry, any overlap
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_hit  <= 1'b0;
            r_ovl  <= 1'b0;
            r_free <= 1'b0;
        end else begin
            if (r_cmp_vld && !r_valid_q && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_cmp_idx;
            end
            if (w_overlap) begin
                r_ovl <= 1'b1;
            end
            if (w_contains && !r_hit) begin
                r_hit       <= 1'b1;
                r_match_idx <= r_cmp_idx;
                r_m         <= w_rd_data;
                r_m_short   <= r_page_end > w_end;
                r_m_exact   <= (w_rd_data.base == r_addr) && (w_rd_data.length == r_len);
            end
        end
    end

    // offset of the looked-up address within the matched range
    always_ff @(posedge i_clk) begin
        if (i_cmd.fix) begin
            r_delta <= r_addr - r_m.base;
        end
    end

    // result of the request
    always_comb begin
        n_status   = RS_INVALID;
        n_fobj     = '0;
        n_foff     = '0;
        n_gen      = r_gen;
        w_map_ok   = 1'b0;
        w_unmap_ok = 1'b0;
        case (r_op)
            OP_MAP: begin
                if (r_arg_bad) begin
                    n_status = RS_INVALID;
                end else if (r_addr_oor || r_ovl) begin
                    n_status = RS_NO_SPACE;
                end else if (!r_free) begin
                    n_status = RS_FULL;
                end else begin
                    n_status = RS_OK;
                    w_map_ok = 1'b1;
                end
            end
            OP_UNMAP: begin
                if (r_addr_oor || r_len == '0 || !r_hit || !r_m_exact) begin
                    n_status = RS_NOT_FOUND;
                end else begin
                    n_status   = RS_OK;
                    w_unmap_ok = 1'b1;
                    n_gen      = r_gen + GEN_W'(1);
                end
            end
            OP_LOOKUP: begin
                if (r_addr_oor || !r_hit || r_m_short) begin
                    n_status = RS_NOT_FOUND;
                end else if ((r_prot & ~r_m.prot) != '0) begin
                    n_status = RS_DENIED;
                end else begin
                    n_status = RS_OK;
                    n_fobj   = r_m.object;
                    n_foff   = r_m.offset + r_delta;
                end
            end
            default: n_status = RS_INVALID;
        endcase
    end

    // valid bits and generation count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_gen   <= GEN_W'(1);
        end else if (i_cmd.commit) begin
            if (w_map_ok) begin
                r_valid[r_free_idx] <= 1'b1;
            end
            if (w_unmap_ok) begin
                r_valid[r_match_idx] <= 1'b0;
            end
            r_gen <= n_gen;
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_rsp_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status  <= n_status;
            r_fobj    <= n_fobj;
            r_foff    <= n_foff;
            r_out_gen <= n_gen;
        end
    end

    assign o_stat.out_free = !r_rsp_valid || i_rsp_ready;
    assign o_rsp_valid     = r_rsp_valid;
    assign o_status        = r_status;
    assign o_found_object  = r_fobj;
    assign o_found_offset  = r_foff;
    assign o_generation    = r_out_gen;

endmodule

`default_nettype wire

@@ hw/rtl/guest_range_map_table.sv @@
// Top level of the guest address range map table.
//
// Usage:
//   i_req carries one request: op (map, unmap, lookup), addr, length,
//   object_id, object_offset, object_size and prot, taken when valid and
//   ready are both high. o_rsp returns exactly one response per request:
//   status, found_object, found_offset and generation.
//   i_cfg_wr_en / i_cfg_wr_data write the guest space size; write it only
//   while no request is in flight.
// Timing:
//   Each request walks the whole table, one stored range per cycle through
//   the registered read port of the entry RAM. A new request is taken only
//   after the previous one has been committed to the response register.
// Reset:
//   Synchronous, active low. All ranges become free, the generation count
//   goes to one and the space size to 2^48. The entry RAM is not cleared.
// Back-pressure:
//   A finished response waits in an output register; the next request may
//   be taken and scanned meanwhile, and its commit holds until the
//   register is free.
`default_nettype none
`include "guest_range_map_table_assert.svh"

module guest_range_map_table import grm_pkg::*; #(
    parameter int MAX_ENTRIES = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [SIZE_W-1:0] i_cfg_wr_data,
    grm_req_if.sink                i_req,
    grm_rsp_if.source              o_rsp
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    t_dp_cmd          w_cmd;
    t_dp_stat         w_stat;
    logic [IDX_W-1:0] w_rd_addr;

    // sequencer
    grm_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_rd_addr   (w_rd_addr)
    );

    // datapath
    grm_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_cmd           (w_cmd),
        .i_rd_addr       (w_rd_addr),
        .o_stat          (w_stat),
        .i_op            (i_req.op),
        .i_addr          (i_req.addr),
        .i_length        (i_req.length),
        .i_object_id     (i_req.object_id),
        .i_object_offset (i_req.object_offset),
        .i_object_size   (i_req.object_size),
        .i_prot          (i_req.prot),
        .o_rsp_valid     (o_rsp.valid),
        .i_rsp_ready     (o_rsp.ready),
        .o_status        (o_rsp.status),
        .o_found_object  (o_rsp.found_object),
        .o_found_offset  (o_rsp.found_offset),
        .o_generation    (o_rsp.generation)
    );

    // a taken request is followed by its bound setup
    `GRM_ASSERT_NEXT(a_accept_then_prep, i_req.valid && i_req.ready, w_cmd.prep, "no setup after request")
    // commit never overwrites a response still waiting
    `GRM_ASSERT_SAME(a_commit_when_free, w_cmd.commit, w_stat.out_free, "commit into busy response")
    // a new response appears only from a commit
    `GRM_ASSERT_SAME(a_rsp_from_commit, $rose(o_rsp.valid), $past(w_cmd.commit), "response without commit")
    // no table read while idle and open for requests
    `GRM_ASSERT_SAME(a_no_scan_idle, i_req.ready, !w_cmd.rd_en, "table read while idle")

endmodule

`default_nettype wire
